// File: design/lsfd_pkg.sv
// ----------------------------------------------------------------------------
// lsfd_pkg
// Shared types and constants of the laser-scanner stream deframer.
// ----------------------------------------------------------------------------
package lsfd_pkg;

    // Header signature bytes, in order of arrival.
    localparam logic [7:0] SIG_B0 = 8'h43;
    localparam logic [7:0] SIG_B1 = 8'h6c;
    localparam logic [7:0] SIG_B2 = 8'h6f;
    localparam logic [7:0] SIG_B3 = 8'h75;
    localparam logic [7:0] SIG_B4 = 8'h64;

    localparam int BYTE_W   = 8;
    localparam int ANGLE_W  = 16;
    localparam int SPAN_W   = 12;
    localparam int IDX_W    = 12;
    localparam int FIELDS_W = 48;
    localparam int OUT_W    = 48;
    localparam int USER_W   = 2;
    localparam int CFG_W    = 16;

    // Divider width: (end - start) * 10 needs 20 bits.
    localparam int DIV_W   = 20;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [SPAN_W-1:0] SPAN_RESET  = 12'd2700;
    localparam logic [ANGLE_W-1:0] START_RESET = 16'd45;

    // Header position codes: 1 means the next byte is header offset 5.
    localparam logic [2:0] HDR_IDLE  = 3'd0;
    localparam logic [2:0] HDR_FIRST = 3'd1;
    localparam logic [2:0] HDR_LAST  = 3'd7;

    localparam logic [2:0] HOLD_FULL = 3'd4;
    localparam logic [1:0] BIP_LAST  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SCAN_START = 1'b0;
    localparam logic CFG_SPAN       = 1'b1;

    typedef enum logic {
        DIV_SEL_STEP  = 1'b0,
        DIV_SEL_TOTAL = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     step_ok;
        logic     step_bad;
        logic     take_total;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic hdr_div;
        logic div_done;
        logic quo_zero;
    } t_stat;

endpackage

// File: design/lsfd_div.sv
// ----------------------------------------------------------------------------
// lsfd_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module lsfd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsfd_pkg::DIV_W-1:0]   i_dividend,
    input  logic [lsfd_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [lsfd_pkg::DIV_W-1:0]   o_quotient
);
    import lsfd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dsr;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       trial;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        trial   = shifted - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!trial[DIV_W]) begin
                r_rem <= trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/lsfd_datapath.sv
// ----------------------------------------------------------------------------
// lsfd_datapath
// Hold line, header parser, point assembly, scan totals and output register.
// ----------------------------------------------------------------------------
module lsfd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsfd_pkg::t_cmd                i_cmd,
    output lsfd_pkg::t_stat               o_stat,
    input  logic [lsfd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [lsfd_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lsfd_pkg::OUT_W-1:0]    o_out_data,
    output logic                          o_out_last,
    output logic [lsfd_pkg::USER_W-1:0]   o_out_user
);
    import lsfd_pkg::*;

    logic [ANGLE_W-1:0]  r_cfg_start;
    logic [SPAN_W-1:0]   r_cfg_span;

    logic [BYTE_W-1:0]   r_held [4];
    logic [2:0]          r_held_cnt;
    logic [2:0]          r_phase;
    logic [FIELDS_W-1:0] r_fields;
    logic [IDX_W-1:0]    r_total;
    logic [IDX_W-1:0]    r_cnt;
    logic [1:0]          r_bip;
    logic [23:0]         r_part;
    logic                r_regular;
    logic                r_invalid;
    logic                r_reg_pend;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_last;
    logic [USER_W-1:0]   r_out_user;

    logic [FIELDS_W-1:0] fields_next;
    logic [ANGLE_W-1:0]  h_start;
    logic [ANGLE_W-1:0]  h_end;
    logic [ANGLE_W-1:0]  h_count;
    logic [ANGLE_W-1:0]  h_diff;
    logic [DIV_W-1:0]    diff10;
    logic                hdr_last;
    logic                hdr_match;
    logic                hdr_bad;
    logic                sig_hit;
    logic                do_hdr;
    logic                do_sig;
    logic                do_fill;
    logic                do_data;
    logic                do_emit;
    logic [IDX_W:0]      cnt_inc;
    logic                is_last;
    logic [BYTE_W-1:0]   oldest;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;

    always_comb begin
        fields_next = {r_fields[FIELDS_W-BYTE_W-1:0], i_byte};
        h_start     = fields_next[47:32];
        h_end       = fields_next[31:16];
        h_count     = fields_next[15:0];
        h_diff      = h_end - h_start;
        diff10      = ({4'b0, h_diff} << 3) + ({4'b0, h_diff} << 1);
        hdr_last    = (r_phase == HDR_LAST);
        hdr_match   = hdr_last && (h_start == r_cfg_start);
        hdr_bad     = (h_count == '0) || (h_end <= h_start);

        sig_hit = (r_held_cnt == HOLD_FULL) && (r_held[0] == SIG_B0) &&
                  (r_held[1] == SIG_B1) && (r_held[2] == SIG_B2) &&
                  (r_held[3] == SIG_B3) && (i_byte == SIG_B4);

        do_hdr  = i_cmd.accept && (r_phase != HDR_IDLE);
        do_sig  = i_cmd.accept && (r_phase == HDR_IDLE) && sig_hit;
        do_fill = i_cmd.accept && (r_phase == HDR_IDLE) && !sig_hit &&
                  (r_held_cnt != HOLD_FULL);
        do_data = i_cmd.accept && (r_phase == HDR_IDLE) && !sig_hit &&
                  (r_held_cnt == HOLD_FULL);
        do_emit = do_data && (r_bip == BIP_LAST);

        oldest  = r_held[0];
        cnt_inc = {1'b0, r_cnt} + 1'b1;
        is_last = (cnt_inc >= {1'b0, r_total});

        // The second division uses the first quotient straight from the divider.
        if (i_cmd.div_sel == DIV_SEL_STEP) begin
            div_dividend = diff10;
            div_divisor  = {4'b0, h_count};
        end else begin
            div_dividend = {{(DIV_W-SPAN_W){1'b0}}, r_cfg_span};
            div_divisor  = div_quo;
        end
    end

    lsfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= START_RESET;
            r_cfg_span  <= SPAN_RESET;
            r_held_cnt  <= '0;
            r_phase     <= HDR_IDLE;
            r_total     <= SPAN_RESET;
            r_cnt       <= '0;
            r_bip       <= '0;
            r_regular   <= 1'b1;
            r_invalid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCAN_START: r_cfg_start <= i_cfg_data;
                    CFG_SPAN:       r_cfg_span  <= i_cfg_data[SPAN_W-1:0];
                    default:        r_cfg_start <= r_cfg_start;
                endcase
            end

            if (do_hdr) begin
                if (hdr_last) begin
                    r_phase <= HDR_IDLE;
                    if (hdr_match) begin
                        r_cnt <= '0;
                        r_bip <= '0;
                        if (hdr_bad) begin
                            r_invalid <= 1'b1;
                            r_regular <= 1'b0;
                        end
                    end
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end

            if (do_sig) begin
                r_held_cnt <= '0;
                r_phase    <= HDR_FIRST;
            end

            if (do_fill) begin
                r_held_cnt <= r_held_cnt + 1'b1;
            end

            if (do_data) begin
                if (do_emit) begin
                    r_bip <= '0;
                    r_cnt <= is_last ? '0 : cnt_inc[IDX_W-1:0];
                end else begin
                    r_bip <= r_bip + 1'b1;
                end
            end

            if (i_cmd.step_bad) begin
                r_invalid <= 1'b1;
                r_regular <= 1'b0;
            end
            if (i_cmd.step_ok) begin
                r_invalid <= 1'b0;
                r_regular <= r_reg_pend;
            end
            // The span is at most 12 bits, so the total never needs limiting.
            if (i_cmd.take_total) begin
                r_total <= div_quo[IDX_W-1:0];
            end

            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_hdr && (r_phase != HDR_FIRST)) begin
            r_fields <= fields_next;
        end
        if (do_hdr && hdr_match) begin
            r_reg_pend <= (diff10 == {4'b0, h_count});
        end
        if (do_fill) begin
            r_held[r_held_cnt[1:0]] <= i_byte;
        end
        if (do_data) begin
            r_held[0] <= r_held[1];
            r_held[1] <= r_held[2];
            r_held[2] <= r_held[3];
            r_held[3] <= i_byte;
            case (r_bip)
                2'd0:    r_part[7:0]   <= oldest;
                2'd1:    r_part[15:8]  <= oldest;
                2'd2:    r_part[23:16] <= oldest;
                default: r_part        <= r_part;
            endcase
        end
        if (do_emit) begin
            r_out_data <= {4'b0, r_cnt, oldest, r_part[23:16], r_part[15:0]};
            r_out_last <= is_last;
            r_out_user <= {r_invalid, r_regular};
        end
    end

    always_comb begin
        o_stat.out_free = !r_out_valid || i_out_ready;
        o_stat.hdr_div  = hdr_match && !hdr_bad;
        o_stat.div_done = div_done;
        o_stat.quo_zero = (div_quo == '0);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_user  = r_out_user;

endmodule

// File: design/lsfd_ctrl.sv
// ----------------------------------------------------------------------------
// lsfd_ctrl
// Sequencer: byte acceptance and the two header divisions.
// ----------------------------------------------------------------------------
module lsfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lsfd_pkg::t_stat i_stat,
    output lsfd_pkg::t_cmd  o_cmd
);
    import lsfd_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV_STEP,
        S_DIV_TOTAL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_RUN: begin
                o_in_ready   = i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
                if (o_cmd.accept && i_stat.hdr_div) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_SEL_STEP;
                    n_state         = S_DIV_STEP;
                end
            end
            S_DIV_STEP: begin
                if (i_stat.div_done) begin
                    if (i_stat.quo_zero) begin
                        o_cmd.step_bad = 1'b1;
                        n_state        = S_RUN;
                    end else begin
                        o_cmd.step_ok   = 1'b1;
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_SEL_TOTAL;
                        n_state         = S_DIV_TOTAL;
                    end
                end
            end
            S_DIV_TOTAL: begin
                if (i_stat.div_done) begin
                    o_cmd.take_total = 1'b1;
                    n_state          = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !o_cmd.accept)
        else $error("byte accepted while a division is running");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state != S_RUN))
        else $error("divider finished with no division pending");

    a_start_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (o_cmd.accept || (r_state == S_DIV_STEP)))
        else $error("division started outside a header or step result");

    a_total_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step_ok |=> (r_state == S_DIV_TOTAL))
        else $error("valid step did not launch the total division");

endmodule

// File: design/lidar_scan_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_frame_deframer_core
// Laser-scanner byte stream deframer: strips headers, rebuilds scan points.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless stalled; a point appears on the output in the cycle
// after the byte that pushes its last data byte out of the hold line, and a point left
// unread blocks input. A matching header with a nonzero count and a rising angle range
// stalls input while the divider runs two passes, or one when the step rounds to zero.
// Synchronous active-low reset restores the register defaults and an empty
// hold line; configuration writes are taken in every cycle.
module lidar_scan_frame_deframer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lsfd_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] distance_mm, [31:16] intensity, [43:32] point_index, [47:44] zero
    output logic [lsfd_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,   // last_of_scan
    // [0] step_regular, [1] step_invalid
    output logic [lsfd_pkg::USER_W-1:0]   m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [lsfd_pkg::CFG_W-1:0]    i_cfg_data
);
    import lsfd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lsfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lsfd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_byte      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_user  (m_axis_tuser)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// File: sim/tb_lidar_scan_frame_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_scan_frame_deframer_core
// Self-checking bench for the laser-scanner stream deframer. A byte stream
// of scan headers, point data, noise and broken signatures is driven with
// random idle gaps on both sides. A scan model in the bench predicts every
// point, and each output point is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_lidar_scan_frame_deframer_core;
    import lsfd_pkg::*;

    localparam int MAX_POINTS  = 4096;
    localparam int SETTLE_CYC  = 60;
    localparam int REPORT_MAX  = 10;

    typedef enum int {
        HK_VALID, HK_REGULAR, HK_ZERO_COUNT, HK_BACKWARD,
        HK_STEP_ZERO, HK_WIDE_STEP, HK_OTHER_START
    } hdr_kind_t;

    typedef struct {
        logic [15:0]      distance;
        logic [15:0]      strength;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             regular;
        logic             invalid;
    } scan_point_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic [USER_W-1:0]     m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    lidar_scan_frame_deframer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Scan model state.
    logic [ANGLE_W-1:0] cfg_start;
    logic [SPAN_W-1:0]  cfg_span;
    logic [7:0]         hold_q [4];
    logic [2:0]         hold_fill;
    logic [2:0]         hdr_pos;
    logic [47:0]        hdr_bits;
    int unsigned        pts_total;
    int unsigned        pts_count;
    logic [1:0]         byte_pos;
    logic [23:0]        pt_partial;
    logic               flg_regular;
    logic               flg_invalid;

    scan_point_t expected_points [$];
    int          mismatch_count;
    int          bytes_sent;
    bit          burst;
    int          rx_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    function automatic void reset_scan_model();
        cfg_start   = START_RESET;
        cfg_span    = SPAN_RESET;
        hold_q      = '{default: 8'h00};
        hold_fill   = '0;
        hdr_pos     = HDR_IDLE;
        hdr_bits    = '0;
        pts_total   = SPAN_RESET;
        pts_count   = 0;
        byte_pos    = '0;
        pt_partial  = '0;
        flg_regular = 1'b1;
        flg_invalid = 1'b0;
    endfunction

    function automatic void apply_scan_header();
        logic [15:0] st;
        logic [15:0] en;
        logic [15:0] cnt;
        int unsigned diff10;
        int unsigned stepw;
        int unsigned tot;
        st  = hdr_bits[47:32];
        en  = hdr_bits[31:16];
        cnt = hdr_bits[15:0];
        if (st != cfg_start) begin
            return;
        end
        pts_count  = 0;
        byte_pos   = '0;
        pt_partial = '0;
        if (cnt == 0 || en <= st) begin
            flg_invalid = 1'b1;
            flg_regular = 1'b0;
            return;
        end
        diff10 = (int'(en) - int'(st)) * 10;
        stepw  = diff10 / cnt;
        if (stepw == 0) begin
            flg_invalid = 1'b1;
            flg_regular = 1'b0;
            return;
        end
        flg_invalid = 1'b0;
        flg_regular = (diff10 == cnt);
        tot = cfg_span / stepw;
        pts_total = (tot > MAX_POINTS) ? MAX_POINTS : tot;
    endfunction

    // Feeds one data byte out of the hold line into point assembly.
    function automatic void assemble_point(input logic [7:0] b);
        scan_point_t pt;
        if (byte_pos != BIP_LAST) begin
            pt_partial[8*byte_pos +: 8] = b;
            byte_pos++;
            return;
        end
        pt.distance = pt_partial[15:0];
        pt.strength = {b, pt_partial[23:16]};
        pt.index    = pts_count[IDX_W-1:0];
        pt.last     = (pts_count + 1 >= pts_total);
        pt.regular  = flg_regular;
        pt.invalid  = flg_invalid;
        expected_points.push_back(pt);
        pts_count  = pt.last ? 0 : ((pts_count + 1) & 32'h1FFF);
        byte_pos   = '0;
        pt_partial = '0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [7:0] oldest;
        if (hdr_pos != HDR_IDLE) begin
            if (hdr_pos != HDR_FIRST) begin
                hdr_bits = {hdr_bits[39:0], b};
            end
            if (hdr_pos == HDR_LAST) begin
                hdr_pos = HDR_IDLE;
                apply_scan_header();
            end else begin
                hdr_pos++;
            end
            return;
        end
        if (hold_fill == HOLD_FULL && hold_q[0] == SIG_B0 && hold_q[1] == SIG_B1 &&
            hold_q[2] == SIG_B2 && hold_q[3] == SIG_B3 && b == SIG_B4) begin
            hold_fill = '0;
            hold_q    = '{default: 8'h00};
            hdr_pos   = HDR_FIRST;
            hdr_bits  = '0;
            return;
        end
        if (hold_fill != HOLD_FULL) begin
            hold_q[hold_fill[1:0]] = b;
            hold_fill++;
            return;
        end
        oldest    = hold_q[0];
        hold_q[0] = hold_q[1];
        hold_q[1] = hold_q[2];
        hold_q[2] = hold_q[3];
        hold_q[3] = b;
        assemble_point(oldest);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [15:0] st, input logic [15:0] en,
                               input logic [15:0] cnt);
        send_byte(SIG_B0);
        send_byte(SIG_B1);
        send_byte(SIG_B2);
        send_byte(SIG_B3);
        send_byte(SIG_B4);
        send_byte(8'($urandom));
        send_byte(st[15:8]);
        send_byte(st[7:0]);
        send_byte(en[15:8]);
        send_byte(en[7:0]);
        send_byte(cnt[15:8]);
        send_byte(cnt[7:0]);
    endtask

    task automatic send_random_bytes(input int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    // Waits until every predicted point is out and any divider pass is over.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SCAN_START) begin
            cfg_start = value;
        end else begin
            cfg_span = value[SPAN_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_scan_config(input logic [15:0] st, input logic [11:0] span);
        drain();
        write_reg(CFG_SCAN_START, st);
        write_reg(CFG_SPAN, {4'($urandom), span});
    endtask

    function automatic void pick_header(input hdr_kind_t kind, output logic [15:0] st,
                                        output logic [15:0] en, output logic [15:0] cnt);
        int room;
        int d;
        int stepw;
        room = 65535 - int'(cfg_start);
        st   = cfg_start;
        en   = 16'($urandom);
        cnt  = 16'($urandom);
        case (kind)
            HK_VALID: begin
                stepw = int'(cfg_span) / $urandom_range(1, 12);
                if (stepw == 0) stepw = 1;
                cnt = 16'($urandom_range(1, 8));
                d   = (stepw * int'(cnt) + 9) / 10;
                if (d > room) d = room;
                en = 16'(int'(cfg_start) + d);
            end
            HK_REGULAR: begin
                d   = (room == 0) ? 0 : $urandom_range(1, (room < 6553) ? room : 6553);
                cnt = 16'(d * 10);
                en  = 16'(int'(cfg_start) + d);
            end
            HK_ZERO_COUNT: begin
                cnt = '0;
            end
            HK_BACKWARD: begin
                en  = 16'($urandom_range(0, int'(cfg_start)));
                cnt = 16'($urandom_range(1, 65535));
            end
            HK_STEP_ZERO: begin
                d   = (room == 0) ? 0 : $urandom_range(1, (room < 100) ? room : 100);
                cnt = 16'(d * 10 + $urandom_range(1, 65535 - d * 10));
                en  = 16'(int'(cfg_start) + d);
            end
            HK_WIDE_STEP: begin
                cnt = 16'd1;
                d   = $urandom_range(int'(cfg_span) / 10 + 1, 6553);
                if (d > room) d = room;
                en = 16'(int'(cfg_start) + d);
            end
            default: begin
                st = cfg_start ^ 16'($urandom_range(1, 65535));
            end
        endcase
    endfunction

    // One frame: mostly a header followed by points, sometimes line noise
    // or a signature that breaks off.
    task automatic send_random_frame();
        int pick;
        int plen;
        logic [15:0] st;
        logic [15:0] en;
        logic [15:0] cnt;
        logic [7:0] sig [5];
        hdr_kind_t kind;
        sig  = '{SIG_B0, SIG_B1, SIG_B2, SIG_B3, SIG_B4};
        pick = $urandom_range(0, 99);
        if (pick < 86) begin
            if (pick < 45)      kind = HK_VALID;
            else if (pick < 55) kind = HK_REGULAR;
            else if (pick < 60) kind = HK_ZERO_COUNT;
            else if (pick < 65) kind = HK_BACKWARD;
            else if (pick < 70) kind = HK_STEP_ZERO;
            else if (pick < 76) kind = HK_WIDE_STEP;
            else                kind = HK_OTHER_START;
            pick_header(kind, st, en, cnt);
            send_header(st, en, cnt);
        end else if (pick < 92) begin
            plen = $urandom_range(1, 4);
            for (int k = 0; k < plen; k++) send_byte(sig[k]);
            send_byte((plen == 4) ? 8'h00 : 8'($urandom));
        end else if (pick < 96) begin
            // Header cut short: the next bytes are taken as header fields.
            for (int k = 0; k < 5; k++) send_byte(sig[k]);
            send_random_bytes($urandom_range(0, 6));
        end else begin
            send_random_bytes($urandom_range(1, 3));
        end
        send_random_bytes(4 * $urandom_range(0, 8));
    endtask

    // Data only after reset: the first four bytes stay in the hold line.
    task automatic test_data_extremes();
        send_random_bytes(4);
        repeat (4) send_byte(8'hFF);
        repeat (4) send_byte(8'h00);
    endtask

    task automatic test_scan_headers();
        // Exact 0.1 degree step, then a count of zero.
        send_header(START_RESET, START_RESET + 16'd1, 16'd10);
        send_header(START_RESET, START_RESET + 16'd9, 16'd0);
        // Step wider than the span: every point is index 0 and last.
        send_header(START_RESET, START_RESET + 16'd500, 16'd1);
        send_random_bytes(8);
        // A header for another start angle leaves the point assembly running.
        send_random_bytes(2);
        send_header(16'hFFFF, 16'h0000, 16'hFFFF);
        send_random_bytes(6);
    endtask

    task automatic test_broken_signature();
        send_byte(SIG_B0);
        send_byte(SIG_B1);
        send_byte(SIG_B2);
        send_byte(SIG_B3);
        send_byte(8'h00);
        send_random_bytes(3);
    endtask

    task automatic test_random_traffic(input logic [15:0] st, input logic [11:0] span,
                                       input int nbytes);
        int stop_at;
        set_scan_config(st, span);
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) send_random_frame();
    endtask

    task automatic test_output_backpressure();
        set_scan_config(16'($urandom), 12'($urandom_range(1, 300)));
        rx_hold_cycles = 250;
        repeat (8) send_random_frame();
    endtask

    // Output side: random stall per point, plus a long hold when requested.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 3);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : check_points
        scan_point_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                note_failure($sformatf("point with none expected: data %h", m_axis_tdata));
            end else begin
                want = expected_points.pop_front();
                if (m_axis_tdata[15:0] !== want.distance ||
                    m_axis_tdata[31:16] !== want.strength ||
                    m_axis_tdata[43:32] !== want.index ||
                    m_axis_tlast !== want.last ||
                    m_axis_tuser[0] !== want.regular ||
                    m_axis_tuser[1] !== want.invalid) begin
                    note_failure($sformatf({"point mismatch: exp dist %h int %h idx %0d ",
                        "last %b reg %b inv %b, got dist %h int %h idx %0d last %b ",
                        "reg %b inv %b"}, want.distance, want.strength, want.index,
                        want.last, want.regular, want.invalid, m_axis_tdata[15:0],
                        m_axis_tdata[31:16], m_axis_tdata[43:32], m_axis_tlast,
                        m_axis_tuser[0], m_axis_tuser[1]));
                end
            end
        end
    end

    initial begin
        mismatch_count = 0;
        bytes_sent     = 0;
        burst          = 1'b0;
        rx_hold_cycles = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SCAN_START;
        i_cfg_data     = '0;
        reset_scan_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_data_extremes();
        test_scan_headers();
        test_broken_signature();
        test_random_traffic(START_RESET, 12'd120, 350);
        burst = 1'b1;
        test_random_traffic(16'h0000, 12'd1, 300);
        burst = 1'b0;
        test_random_traffic(16'hFFFF, 12'hFFF, 250);
        test_output_backpressure();
        test_random_traffic(16'($urandom), 12'($urandom_range(1, 400)), 350);
        test_random_traffic(16'($urandom_range(0, 2000)), 12'hFFF, 200);

        drain();
        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
